// ===== hw/rtl/lkv_pkg.sv =====
package lkv_pkg;

   localparam logic [0:0] OP_GET = 1'b0;
   localparam logic [0:0] OP_PUT = 1'b1;

   localparam int KeyW = 32;
   localparam int ValW = 32;
   localparam int CapW = 5;

   localparam logic [CapW-1:0]        CAPACITY_RESET = 5'd16;
   localparam logic signed [ValW-1:0] MISS_DATA      = -32'sd1;

   typedef struct packed {
      logic [0:0]              req_type;
      logic signed [KeyW-1:0]  key;
      logic signed [ValW-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic                    hit;
      logic signed [ValW-1:0]  data;
   } rsp_item_type;

endpackage

// ===== hw/rtl/lkv_if.sv =====
interface lkv_req_if;
   logic                            valid;
   logic                            ready;
   logic [0:0]                      req_type;
   logic signed [lkv_pkg::KeyW-1:0] key;
   logic signed [lkv_pkg::ValW-1:0] value;

   modport source (output valid, req_type, key, value, input ready);
   modport sink (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic signed [lkv_pkg::ValW-1:0] data;

   modport source (output valid, hit, data, input ready);
   modport sink (input valid, hit, data, output ready);
endinterface

interface lkv_csr_if;
   logic                     valid;
   logic                     ready;
   logic [lkv_pkg::CapW-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink (input valid, capacity, output ready);
endinterface

// ===== hw/rtl/lkv_store.sv =====
module lkv_store #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cfg_we,
   input  logic [lkv_pkg::CapW-1:0]            cfg_capacity,
   input  logic                                go,
   input  lkv_pkg::req_item_type               item,
   output lkv_pkg::rsp_item_type               result,
   output logic [ENTRIES-1:0]                  valid_vec,
   output logic [$clog2(ENTRIES+1)-1:0]        count
);

   localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CntW  = $clog2(ENTRIES + 1);
   localparam int CmpW  = (CntW > lkv_pkg::CapW) ? CntW : lkv_pkg::CapW;

   logic [lkv_pkg::CapW-1:0]  capacity_ff;
   logic [ENTRIES-1:0]        valid_ff;
   logic [ENTRIES-1:0]        valid_in;
   logic [RankW-1:0]          rank_ff [ENTRIES];
   logic [RankW-1:0]          rank_in [ENTRIES];
   logic [CntW-1:0]           count_ff;
   logic [CntW-1:0]           count_in;
   logic [lkv_pkg::KeyW-1:0]  key_ff [ENTRIES];
   logic [lkv_pkg::ValW-1:0]  value_ff [ENTRIES];

   logic [ENTRIES-1:0]        hit_oh;
   logic [ENTRIES-1:0]        free_oh;
   logic [ENTRIES-1:0]        victim_oh;
   logic [ENTRIES-1:0]        tgt_oh;
   logic [ENTRIES-1:0]        bump;
   logic                      hit_any;
   logic [RankW-1:0]          hit_rank;
   logic [lkv_pkg::ValW-1:0]  hit_data;
   logic [CmpW-1:0]           cap_w;
   logic [CntW-1:0]           lim;
   logic                      full;
   logic                      is_put;
   logic                      insert;
   logic                      update;
   logic [RankW-1:0]          last_rank;

   always_comb begin
      cap_w     = CmpW'(capacity_ff);
      lim       = (cap_w > CmpW'(ENTRIES)) ? CntW'(ENTRIES) : CntW'(cap_w);
      full      = (count_ff >= lim);
      is_put    = (item.req_type == lkv_pkg::OP_PUT);
      last_rank = RankW'(count_ff - CntW'(1));
      hit_rank  = '0;
      hit_data  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]    = valid_ff[i] && (key_ff[i] == item.key);
         victim_oh[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         hit_rank     = hit_rank | (hit_oh[i] ? rank_ff[i] : '0);
         hit_data     = hit_data | (hit_oh[i] ? value_ff[i] : '0);
      end
      hit_any = |hit_oh;
      // lowest clear bit of the valid vector
      free_oh = ~valid_ff & (valid_ff + ENTRIES'(1));
      insert  = is_put && !hit_any && (lim != '0);
      tgt_oh  = hit_any ? hit_oh : (full ? victim_oh : free_oh);
      update  = go && (hit_any || insert);

      // an insert ages every other live entry; a hit ages only those above it
      for (int i = 0; i < ENTRIES; i++) begin
         bump[i] = valid_ff[i] && !tgt_oh[i] && (!hit_any || (rank_ff[i] < hit_rank));
      end

      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (update) begin
         valid_in = valid_ff | tgt_oh;
         if (insert && !full && (|free_oh)) begin
            count_in = count_ff + CntW'(1);
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh[i]) begin
               rank_in[i] = '0;
            end else if (bump[i]) begin
               rank_in[i] = rank_ff[i] + RankW'(1);
            end
         end
      end

      result.hit  = hit_any;
      result.data = hit_any ? hit_data : lkv_pkg::MISS_DATA;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkv_pkg::CAPACITY_RESET;
         valid_ff    <= '0;
         count_ff    <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cfg_we) begin
         capacity_ff <= cfg_capacity;
         valid_ff    <= '0;
         count_ff    <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (update && is_put && tgt_oh[i]) begin
            key_ff[i]   <= item.key;
            value_ff[i] <= item.value;
         end
      end
   end

   assign valid_vec = valid_ff;
   assign count     = count_ff;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// LRU key-value cache: fully associative store with least-recently-used replacement.
//
// req_chan carries one request per transaction: req_type (0 get, 1 put), key, value.
// rsp_chan returns one transaction per get: hit and data (stored value, or -1 on a miss).
// A put returns nothing. csr_chan writes the capacity (entries kept before eviction,
// clipped to ENTRIES); a write also empties the store. Write it only while idle.
//
// A request is latched in an input register, then looked up and applied to the store,
// and a get's response is registered in a response register that drives
// rsp_chan.valid. One request per cycle is taken unless a get waits behind a stalled
// response; the combinational key compare and rank update over all ENTRIES slots set that rate.
//
// Reset empties the store and sets capacity to 16. While rsp_chan is stalled the
// response is held; a following put still completes, a following get waits in the
// input register and req_chan.ready drops until the response is taken.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input logic      clock,
   input logic      reset,
   lkv_req_if.sink  req_chan,
   lkv_rsp_if.source rsp_chan,
   lkv_csr_if.sink  csr_chan
);

   localparam int CntW = $clog2(ENTRIES + 1);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   lkv_pkg::req_item_type  stage_item_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lkv_pkg::rsp_item_type  rsp_item_ff;
   lkv_pkg::rsp_item_type  lookup;
   logic                   req_take;
   logic                   rsp_free;
   logic                   advance;
   logic                   stage_get;
   logic                   csr_take;
   logic [ENTRIES-1:0]     valid_vec;
   logic [CntW-1:0]        count;

   always_comb begin
      stage_get = (stage_item_ff.req_type == lkv_pkg::OP_GET);
      rsp_free  = !rsp_valid_ff || rsp_chan.ready;
      advance   = stage_valid_ff && (!stage_get || rsp_free);
      req_take  = req_chan.valid && req_chan.ready;
      csr_take  = csr_chan.valid && csr_chan.ready;

      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && stage_get) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_chan.ready = !stage_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit   = rsp_item_ff.hit;
   assign rsp_chan.data  = rsp_item_ff.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff.req_type <= req_chan.req_type;
         stage_item_ff.key      <= req_chan.key;
         stage_item_ff.value    <= req_chan.value;
      end
      if (advance && stage_get) begin
         rsp_item_ff <= lookup;
      end
   end

   lkv_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .cfg_we       (csr_take),
      .cfg_capacity (csr_chan.capacity),
      .go           (advance),
      .item         (stage_item_ff),
      .result       (lookup),
      .valid_vec    (valid_vec),
      .count        (count)
   );

   // fill count tracks the number of live slots
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      CntW'($countones(valid_vec)) == count)
      else $error("entry count disagrees with live slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CntW'(ENTRIES))
      else $error("entry count exceeds store depth");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> (count == '0) && (valid_vec == '0))
      else $error("capacity write did not empty the store");

   // a get behind a stalled response must not be consumed
   a_get_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && stage_valid_ff && stage_get)
         |=> stage_valid_ff && $stable(stage_item_ff) && $stable(rsp_item_ff))
      else $error("get advanced while response stalled");

endmodule
